### hw/rtl/bus_snoop_scene_command_parser_assert.svh
// ----------------------------------------------------------------------------
// bus_snoop_scene_command_parser_assert
// Assertion helpers for the bus snoop scene command parser.
// Both sample on the rising edge of clk_i and are off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUS_SNOOP_SCENE_COMMAND_PARSER_ASSERT_SVH
`define BUS_SNOOP_SCENE_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication.
`define BSSCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSSCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bsscp_pkg.sv
// ----------------------------------------------------------------------------
// bsscp_pkg
// Types, command codes and parser constants for the bus snoop scene
// command parser.
// ----------------------------------------------------------------------------
package bsscp_pkg;

  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int ARG_W   = 16;
  localparam int ACT_W   = 4;

  // Rotation speed in signed tenths, saturating
  localparam int SPEED_WIDTH = 16;
  typedef logic signed [SPEED_WIDTH-1:0] speed_t;
  localparam speed_t SPEED_MAX = speed_t'({1'b0, {(SPEED_WIDTH-1){1'b1}}});
  localparam speed_t SPEED_MIN = speed_t'({1'b1, {(SPEED_WIDTH-1){1'b0}}});
  localparam speed_t SPEED_ONE = speed_t'(1);

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = $clog2(NUM_AXES);
  localparam logic [AXIS_W-1:0] AXIS_X = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_Y = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] AXIS_Z = AXIS_W'(2);

  localparam logic [ADDR_W-1:0] SNOOP_ADDR_RST = 16'h0680;

  // Staging buffer for multi-byte payloads
  localparam int STAGE_DEPTH = 17;
  localparam int STAGE_IDX_W = $clog2(STAGE_DEPTH);

  // Payload lengths in bytes
  localparam int COLOR_LEN = 3;
  localparam int TRI_LEN   = 18;
  localparam int CAM_LEN   = 3;

  // Expected-byte codes
  localparam int EXP_W = 5;
  localparam logic [EXP_W-1:0] EXP_NONE = 5'd0;
  localparam logic [EXP_W-1:0] EXP_BG   = 5'd1;
  localparam logic [EXP_W-1:0] EXP_COL  = 5'd4;
  localparam logic [EXP_W-1:0] EXP_TRI  = 5'd7;
  localparam logic [EXP_W-1:0] EXP_CAM  = 5'd25;
  localparam logic [EXP_W-1:0] EXP_END  = 5'd28;

  // Command bytes
  localparam logic [BYTE_W-1:0] CMD_BG      = 8'h42; // B
  localparam logic [BYTE_W-1:0] CMD_COLOR   = 8'h43; // C
  localparam logic [BYTE_W-1:0] CMD_DELETE  = 8'h44; // D
  localparam logic [BYTE_W-1:0] CMD_ENTER   = 8'h45; // E
  localparam logic [BYTE_W-1:0] CMD_MOVE    = 8'h4D; // M
  localparam logic [BYTE_W-1:0] CMD_POS     = 8'h50; // P
  localparam logic [BYTE_W-1:0] CMD_RESET   = 8'h52; // R
  localparam logic [BYTE_W-1:0] CMD_STOP    = 8'h53; // S
  localparam logic [BYTE_W-1:0] CMD_TRI     = 8'h54; // T
  localparam logic [BYTE_W-1:0] CMD_DEC_X   = 8'h55; // U
  localparam logic [BYTE_W-1:0] CMD_DEC_Y   = 8'h56; // V
  localparam logic [BYTE_W-1:0] CMD_DEC_Z   = 8'h57; // W
  localparam logic [BYTE_W-1:0] CMD_INC_X   = 8'h58; // X
  localparam logic [BYTE_W-1:0] CMD_INC_Y   = 8'h59; // Y
  localparam logic [BYTE_W-1:0] CMD_INC_Z   = 8'h5A; // Z

  localparam logic [ARG_W-1:0] CAM_BIAS = 16'd128;

  typedef enum logic [ACT_W-1:0] {
    ACT_DELETE = 4'd0,
    ACT_BG     = 4'd1,
    ACT_COLOR  = 4'd2,
    ACT_TRI    = 4'd3,
    ACT_LOADED = 4'd4,
    ACT_FWD    = 4'd5,
    ACT_SPEED  = 4'd6,
    ACT_CAMERA = 4'd7,
    ACT_RESET  = 4'd8
  } action_e;

  typedef struct packed {
    logic [ADDR_W-1:0] bus_address;
    logic              bus_is_read;
    logic [BYTE_W-1:0] bus_data;
  } bus_cycle_t;

  typedef struct packed {
    action_e          action;
    logic [ARG_W-1:0] arg0;
    logic [ARG_W-1:0] arg1;
    logic [ARG_W-1:0] arg2;
    logic [ARG_W-1:0] arg3;
    logic [ARG_W-1:0] arg4;
    logic [ARG_W-1:0] arg5;
    logic [ARG_W-1:0] arg6;
    logic [ARG_W-1:0] arg7;
    logic [ARG_W-1:0] arg8;
  } scene_cmd_t;

endpackage

### hw/rtl/bus_snoop_scene_command_parser.sv
// ----------------------------------------------------------------------------
// bus_snoop_scene_command_parser: snoops host writes and decodes scene commands
// Path: a bus cycle is held in the input register, and its result in the result register.
// Throughput: one bus cycle per clock; the parse is one pass between the
//   input register and the result register, stalled only by out_stall_i.
// Reset: loading mode, no pending payload, rotation speeds zero, address 0x0680.
// ----------------------------------------------------------------------------
`include "bus_snoop_scene_command_parser_assert.svh"

module bus_snoop_scene_command_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // snoop address register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [bsscp_pkg::ADDR_W-1:0] cfg_data_i,
  // observed bus cycles
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bsscp_pkg::bus_cycle_t in_data_i,
  // decoded commands
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bsscp_pkg::scene_cmd_t out_data_o
);

  logic [bsscp_pkg::ADDR_W-1:0] snoop_addr_q;

  logic                  in_valid_q;
  bsscp_pkg::bus_cycle_t in_data_q;

  logic                  out_valid_q;
  bsscp_pkg::scene_cmd_t out_data_q;

  logic                         run_q, run_d;
  logic [bsscp_pkg::EXP_W-1:0]  exp_q, exp_d;
  logic [bsscp_pkg::BYTE_W-1:0] stage_q [bsscp_pkg::STAGE_DEPTH];
  bsscp_pkg::speed_t            speed_q [bsscp_pkg::NUM_AXES];

  logic                         out_free, advance, match;
  logic [bsscp_pkg::BYTE_W-1:0] cmd_byte;
  logic [bsscp_pkg::EXP_W-1:0]  pos;
  logic                         res_valid;
  bsscp_pkg::scene_cmd_t        res;
  logic                         stage_we;
  logic [bsscp_pkg::STAGE_IDX_W-1:0] stage_idx;
  logic                         step_en, step_up, speed_clr;
  logic [bsscp_pkg::AXIS_W-1:0] step_axis;
  bsscp_pkg::speed_t            speed_cur, speed_nxt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snoop_addr_q <= bsscp_pkg::SNOOP_ADDR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      snoop_addr_q <= cfg_data_i;
    end
  end

  // Input register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  assign cmd_byte = in_data_q.bus_data;
  assign match    = advance && !in_data_q.bus_is_read &&
                    (in_data_q.bus_address == snoop_addr_q);

  // Parse one byte
  always_comb begin
    run_d     = run_q;
    exp_d     = exp_q;
    res_valid = 1'b0;
    res       = '0;
    stage_we  = 1'b0;
    stage_idx = '0;
    step_en   = 1'b0;
    step_up   = 1'b0;
    step_axis = bsscp_pkg::AXIS_X;
    speed_clr = 1'b0;
    pos       = '0;

    if (match) begin
      if (exp_q == bsscp_pkg::EXP_NONE) begin
        if (!run_q) begin
          case (cmd_byte)
            bsscp_pkg::CMD_BG:     exp_d = bsscp_pkg::EXP_BG;
            bsscp_pkg::CMD_COLOR:  exp_d = bsscp_pkg::EXP_COL;
            bsscp_pkg::CMD_TRI:    exp_d = bsscp_pkg::EXP_TRI;
            bsscp_pkg::CMD_DELETE: begin
              res_valid  = 1'b1;
              res.action = bsscp_pkg::ACT_DELETE;
            end
            bsscp_pkg::CMD_ENTER: begin
              run_d      = 1'b1;
              res_valid  = 1'b1;
              res.action = bsscp_pkg::ACT_LOADED;
            end
            default: ;
          endcase
        end else begin
          case (cmd_byte)
            bsscp_pkg::CMD_MOVE: begin
              res_valid  = 1'b1;
              res.action = bsscp_pkg::ACT_FWD;
              res.arg0   = bsscp_pkg::ARG_W'(1);
            end
            bsscp_pkg::CMD_STOP: begin
              res_valid  = 1'b1;
              res.action = bsscp_pkg::ACT_FWD;
            end
            bsscp_pkg::CMD_INC_X: begin
              step_en = 1'b1; step_up = 1'b1; step_axis = bsscp_pkg::AXIS_X;
            end
            bsscp_pkg::CMD_INC_Y: begin
              step_en = 1'b1; step_up = 1'b1; step_axis = bsscp_pkg::AXIS_Y;
            end
            bsscp_pkg::CMD_INC_Z: begin
              step_en = 1'b1; step_up = 1'b1; step_axis = bsscp_pkg::AXIS_Z;
            end
            bsscp_pkg::CMD_DEC_X: begin
              step_en = 1'b1; step_axis = bsscp_pkg::AXIS_X;
            end
            bsscp_pkg::CMD_DEC_Y: begin
              step_en = 1'b1; step_axis = bsscp_pkg::AXIS_Y;
            end
            bsscp_pkg::CMD_DEC_Z: begin
              step_en = 1'b1; step_axis = bsscp_pkg::AXIS_Z;
            end
            bsscp_pkg::CMD_POS: exp_d = bsscp_pkg::EXP_CAM;
            bsscp_pkg::CMD_RESET: begin
              speed_clr  = 1'b1;
              res_valid  = 1'b1;
              res.action = bsscp_pkg::ACT_RESET;
            end
            default: ;
          endcase
        end
      end else if (!run_q && (exp_q inside {[bsscp_pkg::EXP_BG:bsscp_pkg::EXP_TRI - 5'd1]})) begin
        pos = (exp_q < bsscp_pkg::EXP_COL) ? exp_q - bsscp_pkg::EXP_BG
                                           : exp_q - bsscp_pkg::EXP_COL;
        if (pos < bsscp_pkg::EXP_W'(bsscp_pkg::COLOR_LEN - 1)) begin
          stage_we  = 1'b1;
          stage_idx = bsscp_pkg::STAGE_IDX_W'(pos);
          exp_d     = exp_q + 5'd1;
        end else begin
          exp_d      = bsscp_pkg::EXP_NONE;
          res_valid  = 1'b1;
          res.action = (exp_q < bsscp_pkg::EXP_COL) ? bsscp_pkg::ACT_BG
                                                    : bsscp_pkg::ACT_COLOR;
          res.arg0   = bsscp_pkg::ARG_W'(stage_q[0]);
          res.arg1   = bsscp_pkg::ARG_W'(stage_q[1]);
          res.arg2   = bsscp_pkg::ARG_W'(cmd_byte);
        end
      end else if (!run_q && (exp_q inside {[bsscp_pkg::EXP_TRI:bsscp_pkg::EXP_CAM - 5'd1]})) begin
        pos = exp_q - bsscp_pkg::EXP_TRI;
        if (pos < bsscp_pkg::EXP_W'(bsscp_pkg::TRI_LEN - 1)) begin
          stage_we  = 1'b1;
          stage_idx = bsscp_pkg::STAGE_IDX_W'(pos);
          exp_d     = exp_q + 5'd1;
        end else begin
          // Coordinates are big-endian byte pairs
          exp_d      = bsscp_pkg::EXP_NONE;
          res_valid  = 1'b1;
          res.action = bsscp_pkg::ACT_TRI;
          res.arg0   = {stage_q[0],  stage_q[1]};
          res.arg1   = {stage_q[2],  stage_q[3]};
          res.arg2   = {stage_q[4],  stage_q[5]};
          res.arg3   = {stage_q[6],  stage_q[7]};
          res.arg4   = {stage_q[8],  stage_q[9]};
          res.arg5   = {stage_q[10], stage_q[11]};
          res.arg6   = {stage_q[12], stage_q[13]};
          res.arg7   = {stage_q[14], stage_q[15]};
          res.arg8   = {stage_q[16], cmd_byte};
        end
      end else if (run_q && (exp_q inside {[bsscp_pkg::EXP_CAM:bsscp_pkg::EXP_END - 5'd1]})) begin
        pos = exp_q - bsscp_pkg::EXP_CAM;
        if (pos < bsscp_pkg::EXP_W'(bsscp_pkg::CAM_LEN - 1)) begin
          stage_we  = 1'b1;
          stage_idx = bsscp_pkg::STAGE_IDX_W'(pos);
          exp_d     = exp_q + 5'd1;
        end else begin
          exp_d      = bsscp_pkg::EXP_NONE;
          res_valid  = 1'b1;
          res.action = bsscp_pkg::ACT_CAMERA;
          res.arg0   = bsscp_pkg::ARG_W'(stage_q[0]) - bsscp_pkg::CAM_BIAS;
          res.arg1   = bsscp_pkg::ARG_W'(stage_q[1]) - bsscp_pkg::CAM_BIAS;
          res.arg2   = bsscp_pkg::ARG_W'(cmd_byte) - bsscp_pkg::CAM_BIAS;
        end
      end else begin
        // Stale expectation: drop the byte
        exp_d = bsscp_pkg::EXP_NONE;
      end
    end

    if (step_en) begin
      res_valid  = 1'b1;
      res.action = bsscp_pkg::ACT_SPEED;
      res.arg0   = bsscp_pkg::ARG_W'(step_axis);
      res.arg1   = bsscp_pkg::ARG_W'(speed_nxt);
    end
  end

  // Saturating speed step
  always_comb begin
    case (step_axis)
      bsscp_pkg::AXIS_Y: speed_cur = speed_q[1];
      bsscp_pkg::AXIS_Z: speed_cur = speed_q[2];
      default:           speed_cur = speed_q[0];
    endcase
    if (step_up) begin
      speed_nxt = (speed_cur == bsscp_pkg::SPEED_MAX) ? speed_cur
                                                       : speed_cur + bsscp_pkg::SPEED_ONE;
    end else begin
      speed_nxt = (speed_cur == bsscp_pkg::SPEED_MIN) ? speed_cur
                                                       : speed_cur - bsscp_pkg::SPEED_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      exp_q <= bsscp_pkg::EXP_NONE;
      for (int i = 0; i < bsscp_pkg::NUM_AXES; i++) begin
        speed_q[i] <= '0;
      end
    end else begin
      run_q <= run_d;
      exp_q <= exp_d;
      if (speed_clr) begin
        for (int i = 0; i < bsscp_pkg::NUM_AXES; i++) begin
          speed_q[i] <= '0;
        end
      end else if (step_en) begin
        case (step_axis)
          bsscp_pkg::AXIS_Y: speed_q[1] <= speed_nxt;
          bsscp_pkg::AXIS_Z: speed_q[2] <= speed_nxt;
          default:           speed_q[0] <= speed_nxt;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_we) begin
      stage_q[stage_idx] <= cmd_byte;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BSSCP_ASSERT_NEXT(a_run_sticky, run_q, run_q, "run mode left without reset")
  `BSSCP_ASSERT_NOW(a_exp_mode, !run_q, exp_q < bsscp_pkg::EXP_CAM,
                    "camera payload pending in loading mode")
  `BSSCP_ASSERT_NOW(a_exp_run, run_q,
                    (exp_q == bsscp_pkg::EXP_NONE) ||
                    (exp_q >= bsscp_pkg::EXP_CAM && exp_q < bsscp_pkg::EXP_END),
                    "geometry payload pending in run mode")
  `BSSCP_ASSERT_NEXT(a_loaded_run,
                     advance && res_valid && (res.action == bsscp_pkg::ACT_LOADED),
                     run_q && out_valid_q, "loaded result without run mode")
  `BSSCP_ASSERT_NOW(a_stall_cause, in_stall_o, in_valid_q && out_valid_q && out_stall_i,
                    "input stalled with free result register")

endmodule
